/* hdl/hsc_pkg.sv */
// Package: shared constants, types and bit-position helpers for the Hamming SEC codec.
`default_nettype none

package hsc_pkg;

  localparam int CODE_W        = 63;
  localparam int DATA_W        = 57;
  localparam int SYN_W         = 6;
  localparam int CFG_W         = 6;
  localparam int MAX_CODE_BITS = 63;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_CLEAN     = 2'd0,
    STAT_CORRECTED = 2'd1,
    STAT_UNCORR    = 2'd2
  } status_t;

  // Code geometry, derived once per configuration write
  typedef struct packed {
    logic [SYN_W-1:0]  n;
    logic [CODE_W-1:0] code_mask;
    logic [DATA_W-1:0] data_mask;
  } geom_t;

  // One finished result
  typedef struct packed {
    logic [CODE_W-1:0] codeword;
    logic [DATA_W-1:0] data;
    logic [1:0]        status;
    logic [SYN_W-1:0]  error_position;
  } result_t;

  // Least r with 2^r >= r + k + 1
  function automatic logic [3:0] check_bits(logic [CFG_W-1:0] k);
    logic [3:0] r;
    r = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if ((8'd1 << r) < (8'(r) + 8'(k) + 8'd1)) r = r + 4'd1;
    end
    return r;
  endfunction

  // Largest k whose codeword still fits
  function automatic int max_k();
    int best;
    best = 0;
    for (int k = 0; k < 64; k++) begin
      if (k + int'(check_bits(CFG_W'(k))) <= MAX_CODE_BITS) best = k;
    end
    return best;
  endfunction

  localparam int K_MAX = max_k();

  // Codeword position (1-based) of data bit idx: the idx-th non-power-of-two slot
  function automatic int data_pos(int idx);
    int cnt;
    int pos;
    cnt = -1;
    pos = 0;
    for (int p = 1; p <= CODE_W; p++) begin
      if ((p & (p - 1)) != 0) begin
        cnt = cnt + 1;
        if (cnt == idx) pos = p;
      end
    end
    return pos;
  endfunction

  // Positions covered by check i (bit j-1 set when position j has bit i set)
  function automatic logic [CODE_W-1:0] cover_mask(int i);
    logic [CODE_W-1:0] m;
    m = '0;
    for (int p = 1; p <= CODE_W; p++) begin
      if (((p >> i) & 1) != 0) m[p-1] = 1'b1;
    end
    return m;
  endfunction

  // Geometry from a data_bits write; oversized k saturates
  function automatic geom_t geom_from_cfg(logic [CFG_W-1:0] v);
    geom_t      g;
    logic [CFG_W-1:0] k;
    logic [3:0] r;
    k = v;
    r = check_bits(k);
    if ((7'(k) + 7'(r)) > 7'(MAX_CODE_BITS)) begin
      k = CFG_W'(K_MAX);
      r = check_bits(k);
    end
    g.n = SYN_W'(7'(k) + 7'(r));
    for (int i = 0; i < CODE_W; i++) g.code_mask[i] = (i < int'(g.n));
    for (int i = 0; i < DATA_W; i++) g.data_mask[i] = (i < int'(k));
    return g;
  endfunction

endpackage

`default_nettype wire

/* hdl/hsc_if.sv */
// Interfaces: request, result and configuration channels of the Hamming SEC codec.
`default_nettype none

interface hsc_in_if import hsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [DATA_W-1:0] data_in;
  logic [CODE_W-1:0] codeword_in;
  modport source (output valid, output op, output data_in, output codeword_in, input ready);
  modport sink   (input valid, input op, input data_in, input codeword_in, output ready);
endinterface

interface hsc_out_if import hsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] codeword_out;
  logic [DATA_W-1:0] data_out;
  logic [1:0]        status;
  logic [SYN_W-1:0]  error_position;
  modport source (output valid, output codeword_out, output data_out, output status,
                  output error_position, input ready);
  modport sink   (input valid, input codeword_out, input data_out, input status,
                  input error_position, output ready);
endinterface

interface hsc_cfg_if import hsc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data_bits;
  modport source (output valid, output data_bits, input ready);
  modport sink   (input valid, input data_bits, output ready);
endinterface

`default_nettype wire

/* hdl/hsc_core.sv */
// Codec datapath: encode, or syndrome, single-bit correction and data extraction.
`default_nettype none

module hsc_core
  import hsc_pkg::*;
(
  input  wire logic              op,
  input  wire logic [DATA_W-1:0] data_in,
  input  wire logic [CODE_W-1:0] codeword_in,
  input  wire geom_t             geom,
  output result_t                res
);

  logic [DATA_W-1:0] dm;
  logic [CODE_W-1:0] enc_word;
  logic [CODE_W-1:0] rx_word;
  logic [CODE_W-1:0] fix_word;
  logic [SYN_W-1:0]  syn;
  logic              syn_pow2;
  logic              syn_err;
  logic              out_of_range;
  logic [DATA_W-1:0] ext_data;

  // Encode: scatter data into non-power slots, then fill check bits
  always_comb begin
    dm       = data_in & geom.data_mask;
    enc_word = '0;
    for (int j = 0; j < DATA_W; j++) enc_word[data_pos(j)-1] = dm[j];
    for (int i = 0; i < SYN_W; i++) enc_word[(1 << i)-1] = ^(enc_word & cover_mask(i));
    enc_word = enc_word & geom.code_mask;
  end

  // Decode: syndrome and correction
  always_comb begin
    rx_word = codeword_in & geom.code_mask;
    for (int i = 0; i < SYN_W; i++) syn[i] = ^(rx_word & cover_mask(i));
    syn_pow2     = (syn != '0) && ((syn & (syn - SYN_W'(1))) == '0);
    syn_err      = (syn != '0) && !syn_pow2;
    out_of_range = syn > geom.n;
    fix_word     = rx_word;
    if (syn_err && !out_of_range) fix_word = rx_word ^ (CODE_W'(1) << (syn - SYN_W'(1)));
    for (int j = 0; j < DATA_W; j++) ext_data[j] = fix_word[data_pos(j)-1];
  end

  // Result select
  always_comb begin
    if (!op) begin
      res.codeword       = enc_word;
      res.data           = dm;
      res.status         = STAT_CLEAN;
      res.error_position = '0;
    end else begin
      res.codeword       = fix_word;
      res.data           = ext_data;
      res.error_position = syn;
      if (!syn_err)          res.status = STAT_CLEAN;
      else if (out_of_range) res.status = STAT_UNCORR;
      else                   res.status = STAT_CORRECTED;
    end
  end

endmodule

`default_nettype wire

/* hdl/hamming_sec_codec_top.sv */
// Top level: Hamming SEC codec with request register, result register and config register.
//
// Hamming single-error-correcting encoder/decoder with a programmable data width
// (data_bits, 1..57; larger values saturate to 57, zero gives an all-zero result).
// One request is taken every clock cycle; a result is presented once its request has passed
// the request register, then the result register, and the pipeline stalls only when the
// result side holds off ready. The codec logic between the two registers is a fixed parity
// network plus one 6-to-63 correction decoder. The code geometry is derived from data_bits
// when it is written and applies from the next request on; write data_bits only while no
// request is in flight.
`default_nettype none

module hamming_sec_codec_top
  import hsc_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  hsc_in_if.sink   in_chan,
  hsc_out_if.source out_chan,
  hsc_cfg_if.sink  cfg_chan
);

  geom_t             geom_r;
  geom_t             geom_nxt;
  logic              s1_valid_r;
  logic              s1_op_r;
  logic [DATA_W-1:0] s1_data_r;
  logic [CODE_W-1:0] s1_cw_r;
  logic              out_valid_r;
  result_t           res_r;
  result_t           res_nxt;
  logic              s2_take;
  logic              s1_take;

  // Configuration: always ready, geometry precomputed on write
  assign cfg_chan.ready = 1'b1;
  assign geom_nxt       = geom_from_cfg(cfg_chan.data_bits);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r <= geom_from_cfg(CFG_W'(4));
    end else if (cfg_chan.valid) begin
      geom_r <= geom_nxt;
    end
  end

  // Handshake: result register frees up when empty or being drained
  assign s2_take       = !out_valid_r || out_chan.ready;
  assign s1_take       = !s1_valid_r || s2_take;
  assign in_chan.ready = s1_take;

  // Request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_take) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && in_chan.valid) begin
      s1_op_r   <= in_chan.op;
      s1_data_r <= in_chan.data_in;
      s1_cw_r   <= in_chan.codeword_in;
    end
  end

  hsc_core u_core (
    .op          (s1_op_r),
    .data_in     (s1_data_r),
    .codeword_in (s1_cw_r),
    .geom        (geom_r),
    .res         (res_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_take) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take && s1_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.codeword_out   = res_r.codeword;
  assign out_chan.data_out       = res_r.data;
  assign out_chan.status         = res_r.status;
  assign out_chan.error_position = res_r.error_position;

endmodule

`default_nettype wire
